@@ hw/rtl/ttw_pkg.sv @@
package ttw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int KEEP    = CELLS - COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int MUL_W   = ADDR_W + 7;

  // Character and attribute codes
  localparam logic [7:0] LINE_FEED   = 8'd10;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h0F;

  // Opcodes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_COLOR   = 3'd1;
  localparam logic [2:0] OP_RECOLOR = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_WRITE   = 3'd5;

  // What a full-screen pass writes into each cell
  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_RECOLOR,
    SW_SCROLL
  } sweep_mode_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] color_value;
    logic [6:0] cell_column;
    logic [5:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic [6:0] cursor_column_out;
    logic [4:0] cursor_row_out;
  } out_item_t;

  // Screen store access: one write and one read per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/text_terminal_writer.sv @@
// An accepted item goes through S_EXEC (and S_RDWAIT for a cell read) to S_DONE,
// then into the output register. Scroll, recolor and clear add one pass over the
// screen store, one cell per cycle through the single store port pair.
// A new item is taken only once the previous one has left S_DONE;
// in_ready_o is high only while the sequencer idles and stays low while a result waits.
// Reset: cursor to 0,0, color 0x0F, then a blanking pass over all COLUMNS*ROWS cells
// with in_ready_o low.
module text_terminal_writer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ttw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ttw_pkg::out_item_t out_item_o
);

  ttw_pkg::mem_req_t  mem_req;
  logic [15:0]        mem_rdata;
  logic               res_valid;
  ttw_pkg::out_item_t res;
  logic               slot_free;
  logic               out_valid_q;
  ttw_pkg::out_item_t out_item_q;

  ttw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ttw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Hold the result item until the consumer takes it
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/ttw_screen_ram.sv @@
module ttw_screen_ram (
  input  logic              clk_i,
  input  ttw_pkg::mem_req_t req_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem_q [ttw_pkg::CELLS];
  logic [15:0] rdata_q;

  // Write one cell, read one cell into the output register
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ttw_ctrl.sv @@
module ttw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttw_pkg::in_item_t   in_item_i,
  input  logic                slot_free_i,
  output logic                res_valid_o,
  output ttw_pkg::out_item_t  res_o,
  output ttw_pkg::mem_req_t   mem_req_o,
  input  logic [15:0]         mem_rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                   state_q, state_d;
  ttw_pkg::in_item_t            item_q, item_d;
  logic [ttw_pkg::COL_W-1:0]    col_q, col_d;
  logic [ttw_pkg::ROW_W-1:0]    row_q, row_d;
  logic [7:0]                   color_q, color_d;
  ttw_pkg::sweep_mode_e         mode_q, mode_d;
  logic [ttw_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         boot_q, boot_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [ttw_pkg::ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic                         pend_blank_q, pend_blank_d;
  logic [7:0]                   rd_char_q, rd_char_d;
  logic [7:0]                   rd_color_q, rd_color_d;

  logic                         use_cursor;
  logic [5:0]                   a_row;
  logic [6:0]                   a_col;
  logic [ttw_pkg::MUL_W-1:0]    prod;
  logic [ttw_pkg::ADDR_W-1:0]   cell_addr;
  logic                         in_range;
  logic                         new_line;
  logic [ttw_pkg::ADDR_W-1:0]   sweep_addr;
  logic [15:0]                  sweep_wdata;
  logic [5:0]                   row_wide;

  // Shared address unit: row * COLUMNS + column, from the cursor or the item
  assign use_cursor = (item_q.opcode == ttw_pkg::OP_PUT);
  assign a_row      = use_cursor ? 6'(row_q) : item_q.cell_row;
  assign a_col      = use_cursor ? 7'(col_q) : item_q.cell_column;
  assign prod       = ttw_pkg::MUL_W'(a_row) * ttw_pkg::MUL_W'(ttw_pkg::COLUMNS)
                    + ttw_pkg::MUL_W'(a_col);
  assign cell_addr  = prod[ttw_pkg::ADDR_W-1:0];
  assign in_range   = (32'(item_q.cell_column) < ttw_pkg::COLUMNS) &&
                      (32'(item_q.cell_row) < ttw_pkg::ROWS);

  assign new_line   = (item_q.char_code == ttw_pkg::LINE_FEED) ||
                      (col_q == ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1));

  assign sweep_addr = cnt_q[ttw_pkg::ADDR_W-1:0];

  // Data for the trailing write of a full-screen pass
  always_comb begin
    if (pend_blank_q) begin
      sweep_wdata = {color_q, ttw_pkg::BLANK_CHAR};
    end else if (mode_q == ttw_pkg::SW_RECOLOR) begin
      sweep_wdata = {color_q, mem_rdata_i[7:0]};
    end else begin
      sweep_wdata = mem_rdata_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    col_d        = col_q;
    row_d        = row_q;
    color_d      = color_q;
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    boot_d       = boot_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_blank_d = pend_blank_q;
    rd_char_d    = rd_char_q;
    rd_color_d   = rd_color_q;
    mem_req_o    = '0;

    // Write back the cell visited in the previous cycle of a pass (read data or blank)
    if (pend_valid_q) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = pend_addr_q;
      mem_req_o.wdata = sweep_wdata;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_char_d  = '0;
        rd_color_d = '0;
        state_d    = S_DONE;
        unique case (item_q.opcode)
          ttw_pkg::OP_PUT: begin
            if (item_q.char_code != ttw_pkg::LINE_FEED) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cell_addr;
              mem_req_o.wdata = {color_q, item_q.char_code};
            end
            if (new_line) begin
              col_d = '0;
              if (32'(row_q) >= ttw_pkg::ROWS - 1) begin
                mode_d  = ttw_pkg::SW_SCROLL;
                cnt_d   = '0;
                state_d = S_SWEEP;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          ttw_pkg::OP_COLOR: begin
            color_d = item_q.color_value;
          end
          ttw_pkg::OP_RECOLOR: begin
            color_d = item_q.color_value;
            mode_d  = ttw_pkg::SW_RECOLOR;
            cnt_d   = '0;
            state_d = S_SWEEP;
          end
          ttw_pkg::OP_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            mode_d  = ttw_pkg::SW_CLEAR;
            cnt_d   = '0;
            state_d = S_SWEEP;
          end
          ttw_pkg::OP_READ: begin
            if (in_range) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = cell_addr;
              state_d         = S_RDWAIT;
            end
          end
          ttw_pkg::OP_WRITE: begin
            if (in_range) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cell_addr;
              mem_req_o.wdata = {item_q.color_value, item_q.char_code};
            end
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        rd_char_d  = mem_rdata_i[7:0];
        rd_color_d = mem_rdata_i[15:8];
        state_d    = S_DONE;
      end

      // Walk every cell: read now where the mode needs it, write next cycle
      S_SWEEP: begin
        if (cnt_q < ttw_pkg::CNT_W'(ttw_pkg::CELLS)) begin
          pend_valid_d = 1'b1;
          pend_addr_d  = sweep_addr;
          cnt_d        = cnt_q + 1'b1;
          unique case (mode_q)
            ttw_pkg::SW_CLEAR: begin
              pend_blank_d = 1'b1;
            end
            ttw_pkg::SW_RECOLOR: begin
              pend_blank_d    = 1'b0;
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = sweep_addr;
            end
            ttw_pkg::SW_SCROLL: begin
              if (cnt_q < ttw_pkg::CNT_W'(ttw_pkg::KEEP)) begin
                pend_blank_d    = 1'b0;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = sweep_addr + ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS);
              end else begin
                pend_blank_d = 1'b1;
              end
            end
            default: begin
              pend_blank_d = 1'b1;
            end
          endcase
        end else begin
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the blanking pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      col_q        <= '0;
      row_q        <= '0;
      color_q      <= ttw_pkg::RESET_COLOR;
      mode_q       <= ttw_pkg::SW_CLEAR;
      cnt_q        <= '0;
      boot_q       <= 1'b1;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      color_q      <= color_d;
      mode_q       <= mode_d;
      cnt_q        <= cnt_d;
      boot_q       <= boot_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    pend_addr_q  <= pend_addr_d;
    pend_blank_q <= pend_blank_d;
    rd_char_q    <= rd_char_d;
    rd_color_q   <= rd_color_d;
  end

  assign row_wide    = 6'(row_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o                   = '0;
    res_o.read_char         = rd_char_q;
    res_o.read_color        = rd_color_q;
    res_o.cursor_column_out = 7'(col_q);
    res_o.cursor_row_out    = row_wide[4:0];
  end

endmodule

@@ hw/rtl/ttw_checker.sv @@
module ttw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ttw_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ttw_pkg::out_item_t out_item_o
);

  // Stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // Sequencer is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one in work");

  // Reported cursor stays on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_item_o.cursor_column_out) < ttw_pkg::COLUMNS) &&
                    (32'(out_item_o.cursor_row_out) < ttw_pkg::ROWS))
    else $error("cursor off screen");

  // A new result never shows up in the cycle after the accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result item too early");

endmodule

bind text_terminal_writer ttw_checker u_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Opcodes the console does not decode
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS    = 280;
  localparam int MAX_GAP         = 16;
  localparam int HOLD_OFF_AT     = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 12000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PRINT_CAP       = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ttw_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ttw_pkg::out_item_t out_item;

  text_terminal_writer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Console shadow: screen cells, cursor and current attribute
  logic [15:0] screen_shadow [ttw_pkg::CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  cur_color;

  ttw_pkg::in_item_t  console_cmds [$];
  ttw_pkg::out_item_t expected_status [$];
  int unsigned        fault_count = 0;

  function automatic void blank_screen();
    for (int i = 0; i < ttw_pkg::CELLS; i++) begin
      screen_shadow[i] = {cur_color, ttw_pkg::BLANK_CHAR};
    end
  endfunction

  // Move to the next line, scrolling up one row from the bottom
  function automatic void advance_line();
    if (cur_row >= ttw_pkg::ROWS - 1) begin
      for (int i = 0; i < ttw_pkg::KEEP; i++) begin
        screen_shadow[i] = screen_shadow[i + ttw_pkg::COLUMNS];
      end
      for (int i = ttw_pkg::KEEP; i < ttw_pkg::CELLS; i++) begin
        screen_shadow[i] = {cur_color, ttw_pkg::BLANK_CHAR};
      end
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endfunction

  // Apply one command to the shadow and return the status it reports
  function automatic ttw_pkg::out_item_t console_step(ttw_pkg::in_item_t cmd);
    ttw_pkg::out_item_t status;
    bit                 hit;
    int unsigned        addr;
    status = '0;
    hit = (cmd.cell_column < ttw_pkg::COLUMNS) && (cmd.cell_row < ttw_pkg::ROWS);
    addr = hit ? cmd.cell_row * ttw_pkg::COLUMNS + cmd.cell_column : 0;
    case (cmd.opcode)
      ttw_pkg::OP_PUT: begin
        if (cmd.char_code == ttw_pkg::LINE_FEED) begin
          advance_line();
        end else begin
          screen_shadow[cur_row * ttw_pkg::COLUMNS + cur_col] = {cur_color, cmd.char_code};
          if (cur_col >= ttw_pkg::COLUMNS - 1) advance_line();
          else cur_col++;
        end
      end
      ttw_pkg::OP_COLOR: cur_color = cmd.color_value;
      ttw_pkg::OP_RECOLOR: begin
        cur_color = cmd.color_value;
        for (int i = 0; i < ttw_pkg::CELLS; i++) screen_shadow[i][15:8] = cmd.color_value;
      end
      ttw_pkg::OP_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      ttw_pkg::OP_READ: begin
        if (hit) {status.read_color, status.read_char} = screen_shadow[addr];
      end
      ttw_pkg::OP_WRITE: begin
        if (hit) screen_shadow[addr] = {cmd.color_value, cmd.char_code};
      end
      default: ;
    endcase
    status.cursor_column_out = 7'(cur_col);
    status.cursor_row_out    = 5'(cur_row);
    return status;
  endfunction

  function automatic ttw_pkg::in_item_t pack_cmd(logic [2:0] op, int ch, int color, int col,
                                                 int row);
    ttw_pkg::in_item_t cmd;
    cmd.opcode      = op;
    cmd.char_code   = 8'(ch);
    cmd.color_value = 8'(color);
    cmd.cell_column = 7'(col);
    cmd.cell_row    = 6'(row);
    return cmd;
  endfunction

  // Random fields; coordinates mostly land on the screen
  function automatic ttw_pkg::in_item_t random_cmd(logic [2:0] op);
    ttw_pkg::in_item_t cmd;
    cmd.opcode      = op;
    cmd.char_code   = 8'($urandom_range(0, 255));
    cmd.color_value = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) begin
      cmd.cell_column = 7'($urandom_range(0, ttw_pkg::COLUMNS - 1));
      cmd.cell_row    = 6'($urandom_range(0, ttw_pkg::ROWS - 1));
    end else begin
      cmd.cell_column = 7'($urandom_range(0, 127));
      cmd.cell_row    = 6'($urandom_range(0, 63));
    end
    return cmd;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_fault(string what);
    fault_count++;
    if (fault_count <= PRINT_CAP) $display("ERROR: %s", what);
  endtask

  task automatic check_field(int unsigned idx, string name, int got, int want);
    if (got != want)
      report_fault($sformatf("item %0d: %s got 0x%0h, want 0x%0h", idx, name, got, want));
  endtask

  // Driver: present queued commands with random gaps
  int unsigned send_gap = 0;
  bit          calm_send = 1'b0;

  always @(posedge clk) begin : drive
    logic              valid_n;
    ttw_pkg::in_item_t item_n;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      valid_n = in_valid;
      item_n  = in_item;
      if (in_valid && in_ready) begin
        expected_status.push_back(console_step(in_item));
        if ($urandom_range(0, 29) == 0) calm_send = !calm_send;
        send_gap = draw_wait(calm_send);
        valid_n  = 1'b0;
      end
      if (!valid_n) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (console_cmds.size() != 0) begin
          item_n  = console_cmds.pop_front();
          valid_n = 1'b1;
        end
      end
      in_valid <= valid_n;
      in_item  <= item_n;
    end
  end

  // Monitor: accept status items with random stalls and one long hold-off
  int unsigned recv_wait = 0;
  int unsigned results_seen = 0;
  bit          calm_recv = 1'b0;

  always @(posedge clk) begin : observe
    logic               ready_n;
    ttw_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_n = out_ready;
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          report_fault($sformatf("item %0d: status with no command pending", results_seen));
        end else begin
          want = expected_status.pop_front();
          check_field(results_seen, "read_char", int'(out_item.read_char),
                      int'(want.read_char));
          check_field(results_seen, "read_color", int'(out_item.read_color),
                      int'(want.read_color));
          check_field(results_seen, "cursor_column_out", int'(out_item.cursor_column_out),
                      int'(want.cursor_column_out));
          check_field(results_seen, "cursor_row_out", int'(out_item.cursor_row_out),
                      int'(want.cursor_row_out));
        end
        results_seen++;
        if ($urandom_range(0, 29) == 0) calm_recv = !calm_recv;
        if (results_seen == HOLD_OFF_AT) recv_wait = HOLD_OFF_CYCLES;
        else recv_wait = draw_wait(calm_recv);
        ready_n = (recv_wait == 0);
      end else if (!out_ready) begin
        if (recv_wait != 0) recv_wait--;
        if (recv_wait == 0) ready_n = 1'b1;
      end
      out_ready <= ready_n;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin : run
    ttw_pkg::in_item_t cmd;
    int unsigned       queued;
    int unsigned       burst;
    int unsigned       pick;
    logic [2:0]        op;

    // Shadow reset state
    cur_col   = 0;
    cur_row   = 0;
    cur_color = ttw_pkg::RESET_COLOR;
    blank_screen();

    // Directed: corners, out-of-range cells, extreme bytes, every opcode
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_WRITE, 8'hFF, 8'hFF, ttw_pkg::COLUMNS - 1,
                                    ttw_pkg::ROWS - 1));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, ttw_pkg::COLUMNS - 1,
                                    ttw_pkg::ROWS - 1));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_WRITE, 8'h00, 8'h00, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_WRITE, 8'h55, 8'hAA, ttw_pkg::COLUMNS, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_WRITE, 8'h55, 8'hAA, 0, ttw_pkg::ROWS));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_WRITE, 8'hFF, 8'hFF, 127, 63));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 8'hFF, 8'hFF, ttw_pkg::COLUMNS, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 0, ttw_pkg::ROWS));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 127, 63));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_PUT, 8'h00, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_PUT, 8'hFF, 8'hFF, 127, 63));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_COLOR, 0, 8'hF0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_PUT, 8'h41, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_PUT, ttw_pkg::LINE_FEED, 0, 0, 0));
    console_cmds.push_back(pack_cmd(OP_SPARE_A, 8'hFF, 8'hFF, 127, 63));
    console_cmds.push_back(pack_cmd(OP_SPARE_B, 8'hFF, 8'hFF, 127, 63));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_RECOLOR, 0, 8'h00, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 1, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_CLEAR, 0, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_READ, 0, 0, 0, 0));
    console_cmds.push_back(pack_cmd(ttw_pkg::OP_COLOR, 0, 8'hFF, 0, 0));

    // Random: line-feed runs to reach the bottom and scroll, text runs
    // that wrap, and single commands
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        burst = $urandom_range(5, 26);
        repeat (burst) begin
          cmd = random_cmd(ttw_pkg::OP_PUT);
          cmd.char_code = ttw_pkg::LINE_FEED;
          console_cmds.push_back(cmd);
          queued++;
        end
      end else if (pick < 55) begin
        burst = ($urandom_range(0, 4) == 0)
              ? $urandom_range(ttw_pkg::COLUMNS - 2, ttw_pkg::COLUMNS + 6)
              : $urandom_range(3, 30);
        repeat (burst) begin
          cmd = random_cmd(ttw_pkg::OP_PUT);
          if ($urandom_range(0, 11) == 0) cmd.char_code = ttw_pkg::LINE_FEED;
          console_cmds.push_back(cmd);
          queued++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = ttw_pkg::OP_READ;
        else if (pick < 65) op = ttw_pkg::OP_WRITE;
        else if (pick < 80) op = ttw_pkg::OP_COLOR;
        else if (pick < 87) op = ttw_pkg::OP_RECOLOR;
        else if (pick < 92) op = ttw_pkg::OP_CLEAR;
        else if (pick < 96) op = OP_SPARE_A;
        else op = OP_SPARE_B;
        console_cmds.push_back(random_cmd(op));
        if (op != OP_SPARE_A && op != OP_SPARE_B) queued++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then give stray items a chance to show up
    while (console_cmds.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
